// ----- src/midi_track_event_serializer_defines.svh -----
// ----------------------------------------------------------------------------
// midi track event serializer defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_SERIALIZER_DEFINES_SVH
`define MIDI_TRACK_EVENT_SERIALIZER_DEFINES_SVH

// checked only while out of reset
`define MTES_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked also during reset
`define MTES_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- src/mtes_pkg.sv -----
// ----------------------------------------------------------------------------
// mtes_pkg
// shared constants and types of the midi track event serializer
// ----------------------------------------------------------------------------
package mtes_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam int EVT_TIME_W  = 32;
    localparam int BYTE_W      = 8;
    localparam int IN_DATA_W   = EVT_TIME_W + BYTE_W;
    localparam int IN_USER_W   = 2;
    localparam int OUT_USER_W  = 1;

    localparam int USR_FIRST   = 0;
    localparam int USR_START   = 1;
    localparam int USR_RUN_END = 0;

    localparam int DELTA_W     = 32;
    localparam int VLQ_BITS    = 7;
    localparam int VLQ_GROUPS  = 5;
    localparam int VLQ_W       = VLQ_GROUPS * VLQ_BITS;
    localparam int IDX_W       = $clog2(VLQ_GROUPS);

    localparam logic [BYTE_W-1:0] VLQ_MASK   = 8'h7F;
    localparam logic [BYTE_W-1:0] VLQ_CONT   = 8'h80;
    localparam logic [BYTE_W-1:0] SYS_STATUS = 8'hF0;

    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [BYTE_W-1:0]  data;
        logic               first;
        logic               emit;
        logic               last;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

endpackage

// ----- src/midi_track_event_serializer.sv -----
// ----------------------------------------------------------------------------
// midi_track_event_serializer
// encodes midi event bytes into track data with vlq deltas and running status
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_axis    in   tvalid / tready    tdata: event_time, event_byte
//                                   tuser: first_of_event, track_start
//                                   tlast: last_of_event
// m_axis    out  tvalid / tready    tdata: out_byte
//                                   tuser: run_end
//                                   tlast: event_end
//
// one output byte per cycle from the back part's registered output while it has bytes and the output is not stalled
// a data byte gives one output byte, a status byte 1 to 6 output bytes (delta bytes + status)
// request accepted whenever the command queue has room, FIFO_DEPTH entries
// synchronous reset clears time, running status, queue and output in each reset cycle
// ----------------------------------------------------------------------------
module midi_track_event_serializer import mtes_pkg::*; #(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // event_time, event_byte
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,  // first_of_event, track_start
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [BYTE_W-1:0]     o_m_axis_tdata,  // out_byte
    output logic [OUT_USER_W-1:0] o_m_axis_tuser,  // run_end
    output logic                  o_m_axis_tlast
);

    logic push;
    t_cmd push_cmd;
    logic full;
    logic pop;
    t_cmd pop_cmd;
    logic empty;

    mtes_front #(
        .TIME_BITS(TIME_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .i_tlast  (i_s_axis_tlast),
        .o_push   (push),
        .o_cmd    (push_cmd),
        .i_full   (full)
    );

    mtes_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_cmd),
        .o_empty     (empty)
    );

    mtes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!empty),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tuser     (o_m_axis_tuser),
        .o_tlast     (o_m_axis_tlast)
    );

endmodule

// ----- src/mtes_fifo.sv -----
// ----------------------------------------------------------------------------
// mtes_fifo
// small register queue between the front and back parts
// ----------------------------------------------------------------------------
module mtes_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full     = (r_count == CNT_FULL);
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign push_ok    = i_push && !o_full;
    assign pop_ok     = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- src/mtes_front.sv -----
// ----------------------------------------------------------------------------
// mtes_front
// accepts input bytes, tracks time and running status, queues commands
// ----------------------------------------------------------------------------
module mtes_front import mtes_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [IN_DATA_W-1:0] i_tdata,
    input  logic [IN_USER_W-1:0] i_tuser,
    input  logic                 i_tlast,
    output logic                 o_push,
    output t_cmd                 o_cmd,
    input  logic                 i_full
);

    logic [TIME_BITS-1:0] r_prev, n_prev;
    logic [BYTE_W-1:0]    r_rs, n_rs;
    logic [TIME_BITS-1:0] t;
    logic [BYTE_W-1:0]    b;
    logic                 first;
    logic                 start;
    logic                 accept;
    logic [TIME_BITS-1:0] prev_eff;
    logic [BYTE_W-1:0]    rs_eff;
    logic                 later;
    logic [TIME_BITS-1:0] delta;
    logic                 emit;

    assign t        = i_tdata[TIME_BITS-1:0];
    assign b        = i_tdata[IN_DATA_W-1:EVT_TIME_W];
    assign first    = i_tuser[USR_FIRST];
    assign start    = i_tuser[USR_START];
    assign o_tready = !i_full;
    assign accept   = i_tvalid && o_tready;
    assign prev_eff = start ? '0 : r_prev;
    assign rs_eff   = start ? '0 : r_rs;
    assign later    = (t >= prev_eff);
    assign delta    = later ? (t - prev_eff) : '0;

    always_comb begin
        n_prev = prev_eff;
        n_rs   = rs_eff;
        emit   = 1'b1;
        if (first) begin
            if (later) begin
                n_prev = t;
            end
            if (b inside {[VLQ_CONT:SYS_STATUS - 1'b1]}) begin
                emit = (b != rs_eff);
                n_rs = b;
            end else begin
                n_rs = '0;
            end
        end
    end

    always_comb begin
        o_push      = accept;
        o_cmd.delta = DELTA_W'(delta);
        o_cmd.data  = b;
        o_cmd.first = first;
        o_cmd.emit  = emit;
        o_cmd.last  = i_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_rs   <= '0;
        end else if (accept) begin
            r_prev <= n_prev;
            r_rs   <= n_rs;
        end
    end

endmodule

// ----- src/mtes_back.sv -----
// ----------------------------------------------------------------------------
// mtes_back
// expands queued commands into delta, status and data bytes, one per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module mtes_back import mtes_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_pop,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [BYTE_W-1:0]     o_tdata,
    output logic [OUT_USER_W-1:0] o_tuser,
    output logic                  o_tlast
);

    t_cmd                  r_cmd;
    logic                  r_busy, n_busy;
    logic                  r_in_delta, n_in_delta;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_byte;
    logic                  r_out_run_end;
    logic                  r_out_event_end;

    logic                  advance;
    logic                  step;
    logic                  last_byte;
    logic                  finish;
    logic                  load;
    logic [VLQ_W-1:0]      cur_ext;
    logic [VLQ_W-1:0]      in_ext;
    logic [VLQ_BITS-1:0]   grp;
    logic [BYTE_W-1:0]     cur_byte;
    logic [IDX_W-1:0]      load_idx;

    assign cur_ext = {{(VLQ_W - DELTA_W){1'b0}}, r_cmd.delta};
    assign in_ext  = {{(VLQ_W - DELTA_W){1'b0}}, i_cmd.delta};

    always_comb begin
        grp = '0;
        for (int g = 0; g < VLQ_GROUPS; g++) begin
            if (r_idx == IDX_W'(g)) begin
                grp = cur_ext[g*VLQ_BITS +: VLQ_BITS];
            end
        end
    end

    always_comb begin
        load_idx = '0;
        for (int g = 1; g < VLQ_GROUPS; g++) begin
            if ((in_ext >> (g * VLQ_BITS)) != '0) begin
                load_idx = IDX_W'(g);
            end
        end
    end

    always_comb begin
        if (r_in_delta) begin
            cur_byte  = {1'b0, grp} & VLQ_MASK;
            if (r_idx != '0) begin
                cur_byte = cur_byte | VLQ_CONT;
            end
            last_byte = (r_idx == '0) && !r_cmd.emit;
        end else begin
            cur_byte  = r_cmd.data;
            last_byte = 1'b1;
        end
    end

    assign advance = !r_out_valid || i_tready;
    assign step    = r_busy && advance;
    assign finish  = step && last_byte;
    assign load    = i_cmd_valid && (!r_busy || finish);
    assign o_pop   = load;

    always_comb begin
        n_busy     = r_busy;
        n_in_delta = r_in_delta;
        n_idx      = r_idx;
        if (step) begin
            if (r_in_delta) begin
                if (r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                end else begin
                    n_in_delta = 1'b0;
                end
            end
            if (finish) begin
                n_busy = 1'b0;
            end
        end
        if (load) begin
            n_busy     = 1'b1;
            n_in_delta = i_cmd.first;
            n_idx      = load_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_in_delta  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_in_delta <= n_in_delta;
            r_idx      <= n_idx;
            if (advance) begin
                r_out_valid <= step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
        if (step) begin
            r_out_byte      <= cur_byte;
            r_out_run_end   <= last_byte;
            r_out_event_end <= last_byte && r_cmd.last;
        end
    end

    assign o_tvalid             = r_out_valid;
    assign o_tdata              = r_out_byte;
    assign o_tuser[USR_RUN_END] = r_out_run_end;
    assign o_tlast              = r_out_event_end;

endmodule

// ----- src/mtes_checker.sv -----
// ----------------------------------------------------------------------------
// mtes_checker
// port level checks of the midi track event serializer
// ----------------------------------------------------------------------------
`include "midi_track_event_serializer_defines.svh"

module mtes_checker import mtes_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    input  logic                  i_s_axis_tlast,
    input  logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [BYTE_W-1:0]     o_m_axis_tdata,
    input  logic [OUT_USER_W-1:0] o_m_axis_tuser,
    input  logic                  o_m_axis_tlast
);

    `MTES_ASSERT_RST(a_rst_no_out, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

    `MTES_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "stalled output changed")

    `MTES_ASSERT(a_evt_end_run_end, o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser[USR_RUN_END], "event end without run end")

endmodule

bind midi_track_event_serializer mtes_checker u_chk (.*);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for midi_track_event_serializer: a scoreboard class
// predicts the vlq delta and running status bytes of every accepted request,
// directed events cover delta sizes and status cases, random events follow,
// with random gaps on both sides and one long output hold-off
// ----------------------------------------------------------------------------
import mtes_pkg::*;

class track_byte_board;
    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic              run_end;
        logic              event_end;
    } t_track_byte;

    t_track_byte         due_q[$];
    logic [DELTA_W-1:0]  prev_tick;
    logic [BYTE_W-1:0]   held_status;
    int                  errors;

    function new();
        prev_tick   = '0;
        held_status = '0;
        errors      = 0;
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    function int pending();
        return due_q.size();
    endfunction

    // predicted bytes of one accepted request
    function void note_request(logic [EVT_TIME_W-1:0] evt_time, logic [BYTE_W-1:0] evt_byte,
                               logic is_first, logic is_last, logic is_start);
        t_track_byte        row[$];
        t_track_byte        item;
        logic [VLQ_W-1:0]   delta;
        logic [BYTE_W-1:0]  grp;
        int                 groups;
        if (is_start) begin
            prev_tick   = '0;
            held_status = '0;
        end
        item.run_end   = 1'b0;
        item.event_end = 1'b0;
        if (is_first) begin
            delta = '0;
            if (evt_time >= prev_tick) begin
                delta     = VLQ_W'(evt_time - prev_tick);
                prev_tick = evt_time;
            end
            groups = 1;
            while (groups < VLQ_GROUPS && (delta >> (VLQ_BITS * groups)) != 0)
                groups++;
            for (int i = groups - 1; i >= 0; i--) begin
                grp = BYTE_W'(delta >> (VLQ_BITS * i)) & VLQ_MASK;
                if (i > 0)
                    grp = grp | VLQ_CONT;
                item.out_byte = grp;
                row.insert(row.size(), item);
            end
            if (evt_byte >= SYS_STATUS || evt_byte < VLQ_CONT) begin
                item.out_byte = evt_byte;
                row.insert(row.size(), item);
                held_status = '0;
            end else if (evt_byte != held_status) begin
                item.out_byte = evt_byte;
                row.insert(row.size(), item);
                held_status = evt_byte;
            end
        end else begin
            item.out_byte = evt_byte;
            row.insert(row.size(), item);
        end
        row[row.size()-1].run_end   = 1'b1;
        row[row.size()-1].event_end = is_last;
        foreach (row[i])
            due_q.insert(due_q.size(), row[i]);
    endfunction

    task check_byte(logic [BYTE_W-1:0] got_byte, logic got_run_end,
                    logic got_event_end);
        t_track_byte want;
        if (due_q.size() == 0) begin
            report($sformatf("unexpected byte %02h run_end %b event_end %b",
                             got_byte, got_run_end, got_event_end));
        end else begin
            want = due_q.pop_front();
            if (got_byte !== want.out_byte || got_run_end !== want.run_end ||
                got_event_end !== want.event_end)
                report($sformatf("got byte %02h run_end %b event_end %b, want %02h %b %b",
                                 got_byte, got_run_end, got_event_end,
                                 want.out_byte, want.run_end, want.event_end));
        end
    endtask
endclass

module tb;
    localparam int IDLE_LIMIT  = 3000;
    localparam int NUM_ITEMS   = 310;
    localparam int HOLD_CYCLES = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // event_time, event_byte
    logic [IN_USER_W-1:0]  s_tuser = '0;   // first_of_event, track_start
    logic                  s_tlast = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  m_tready = 1'b0;
    logic [BYTE_W-1:0]     o_m_axis_tdata;  // out_byte
    logic [OUT_USER_W-1:0] o_m_axis_tuser;  // run_end
    logic                  o_m_axis_tlast;

    track_byte_board sb = new();

    int          n_sent = 0;
    int          n_got = 0;
    int          idle_cycles = 0;
    int          tx_burst_left = 0;
    int          rx_stall = 0;
    int          rx_mode_left = 0;
    logic        rx_free = 1'b0;
    logic        rx_held = 1'b0;

    midi_track_event_serializer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic put_item(logic [EVT_TIME_W-1:0] evt_time, logic [BYTE_W-1:0] evt_byte,
                            logic is_first, logic is_last, logic is_start);
        int gap;
        if (tx_burst_left > 0) begin
            gap = 0;
            tx_burst_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 19) == 0)
                tx_burst_left = $urandom_range(10, 30);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid            <= 1'b1;
        s_tdata             <= {evt_byte, evt_time};
        s_tuser[USR_FIRST]  <= is_first;
        s_tuser[USR_START]  <= is_start;
        s_tlast             <= is_last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(evt_time, evt_byte, is_first, is_last, is_start);
        n_sent++;
    endtask

    // output side: random stalls, free-running stretches, one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            sb.check_byte(o_m_axis_tdata, o_m_axis_tuser[USR_RUN_END], o_m_axis_tlast);
            n_got++;
        end
        if (rx_mode_left == 0) begin
            rx_free      <= ($urandom_range(0, 3) == 0);
            rx_mode_left <= $urandom_range(20, 80);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        if (!rx_held && n_got >= 40) begin
            rx_held  <= 1'b1;
            rx_stall <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (!rx_free && $urandom_range(0, 2) == 0) begin
            rx_stall <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** midi_track_event_serializer: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [EVT_TIME_W-1:0] tick;
        logic [EVT_TIME_W-1:0] evt_t;
        logic [BYTE_W-1:0]     status;
        logic                  is_start;
        logic                  drop_last;
        int                    r;
        int                    n_data;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: delta size boundaries and status cases
        put_item(32'h0000_0000, 8'h90, 1'b1, 1'b0, 1'b1);
        put_item(32'h0000_0000, 8'h3C, 1'b0, 1'b0, 1'b0);
        put_item(32'h0000_0000, 8'h7F, 1'b0, 1'b1, 1'b0);
        // suppressed status that ends the event
        put_item(32'h0000_007F, 8'h90, 1'b1, 1'b1, 1'b0);
        put_item(32'h0000_00FF, 8'h80, 1'b1, 1'b0, 1'b0);
        put_item(32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0);
        put_item(32'h0000_0000, 8'hFF, 1'b0, 1'b1, 1'b0);
        put_item(32'h0000_40FE, 8'hF0, 1'b1, 1'b0, 1'b0);
        put_item(32'h0000_0000, 8'hF7, 1'b0, 1'b1, 1'b0);
        put_item(32'h0000_80FE, 8'hFF, 1'b1, 1'b1, 1'b0);
        // earlier time saturates to zero
        put_item(32'h0000_0005, 8'hC0, 1'b1, 1'b0, 1'b0);
        put_item(32'h0000_0000, 8'h12, 1'b0, 1'b1, 1'b0);
        // status below 0x80
        put_item(32'h0020_80FD, 8'h45, 1'b1, 1'b1, 1'b0);
        put_item(32'h0040_80FD, 8'hEF, 1'b1, 1'b0, 1'b0);
        put_item(32'h0000_0000, 8'h40, 1'b0, 1'b1, 1'b0);
        put_item(32'h0FFF_FFFF, 8'hB0, 1'b1, 1'b1, 1'b1);
        put_item(32'h1000_0000, 8'hB0, 1'b1, 1'b1, 1'b1);
        put_item(32'hFFFF_FFFF, 8'hB0, 1'b1, 1'b1, 1'b0);
        // data byte with no event started
        put_item(32'h5A5A_A5A5, 8'hA5, 1'b0, 1'b0, 1'b1);
        put_item(32'hFFFF_FFFF, 8'hE5, 1'b1, 1'b1, 1'b0);
        put_item(32'hFFFF_FFFF, 8'hE5, 1'b1, 1'b1, 1'b0);
        put_item(32'h1234_5678, 8'h80, 1'b0, 1'b1, 1'b0);

        tick = '0;
        while (n_sent < NUM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                put_item($urandom, 8'($urandom_range(0, 255)), 1'($urandom),
                         1'($urandom), 1'($urandom));
            end else begin
                is_start = ($urandom_range(0, 29) == 0);
                if (is_start)
                    tick = '0;
                r = $urandom_range(0, 99);
                if (r < 15)      evt_t = tick;
                else if (r < 45) evt_t = tick + $urandom_range(1, 127);
                else if (r < 65) evt_t = tick + $urandom_range(128, 16383);
                else if (r < 78) evt_t = tick + $urandom_range(16384, 2097151);
                else if (r < 86) evt_t = tick + $urandom_range(2097152, 268435455);
                else if (r < 92) evt_t = $urandom;
                else             evt_t = tick - $urandom_range(1, 1000);
                if (evt_t >= tick)
                    tick = evt_t;
                r = $urandom_range(0, 99);
                if (r < 55)
                    status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 1))};
                else if (r < 75)
                    status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
                else if (r < 92)
                    status = {4'hF, 4'($urandom_range(0, 15))};
                else
                    status = 8'($urandom_range(0, 127));
                n_data = $urandom_range(0, 3);
                drop_last = ($urandom_range(0, 11) == 0);
                if ($urandom_range(0, 24) == 0)
                    put_item($urandom, 8'($urandom_range(0, 255)), 1'b0, 1'($urandom),
                             is_start);
                put_item(evt_t, status, 1'b1, n_data == 0 && !drop_last, is_start);
                for (int i = 0; i < n_data; i++)
                    put_item($urandom,
                             ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, 127)),
                             1'b0, i == n_data - 1 && !drop_last, 1'b0);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d bytes never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("** midi_track_event_serializer: PASSED **");
        else
            $display("** midi_track_event_serializer: FAILED **");
        $finish;
    end
endmodule

// ----- midi_track_event_serializer.f -----
+incdir+src
src/mtes_pkg.sv
src/mtes_fifo.sv
src/mtes_front.sv
src/mtes_back.sv
src/midi_track_event_serializer.sv
src/mtes_checker.sv
test/tb.sv
